// ===== design/wnm_pkg.sv =====
// Package for the wildcard name matcher: field widths, pattern codes,
// register indexes, the configuration view struct and the case-fold helper.
// No dependencies.
package wnm_pkg;

	localparam int MAX_PATTERN_DEF = 32;
	localparam int LEN_W           = 6;
	localparam int CHAR_W          = 8;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_IDX_W       = 3;
	localparam int CHARS_PER_WORD  = CFG_DATA_W / CHAR_W;

	localparam logic [CHAR_W-1:0] CH_ANY  = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_ENABLE = 3'd0,
		REG_PATTERN_LEN  = 3'd1,
		REG_CHARS_0_7    = 3'd2,
		REG_CHARS_8_15   = 3'd3,
		REG_CHARS_16_23  = 3'd4,
		REG_CHARS_24_31  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic             enable;
		logic [LEN_W-1:0] eff_len;
	} cfg_view_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== design/wnm_cfg_regs.sv =====
// Configuration registers of the wildcard name matcher: enable, length
// (clamped to MAX_PATTERN) and pattern bytes, with a byte read port.
// Depends on wnm_pkg.
module wnm_cfg_regs import wnm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [LEN_W-1:0]      rd_pos,
	output logic [CHAR_W-1:0]     rd_char,
	output cfg_view_t             view
);

	localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int DEPTH  = 1 << PIDX_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

	logic                 enable_q;
	logic [LEN_W-1:0]     len_q;
	logic [CHAR_W-1:0]    pattern_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			len_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MATCH_ENABLE) begin
				enable_q <= cfg_wdata[0];
			end
			if (cfg_index == REG_PATTERN_LEN) begin
				len_q <= cfg_wdata[LEN_W-1:0];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_byte
		localparam logic [CFG_IDX_W-1:0] WORD_IDX =
			CFG_IDX_W'(int'(REG_CHARS_0_7) + g / CHARS_PER_WORD);
		localparam int LANE = (g % CHARS_PER_WORD) * CHAR_W;
		localparam bit IN_USE = (g < MAX_PATTERN);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pattern_q[g] <= '0;
			end else if (IN_USE && cfg_we && cfg_index == WORD_IDX) begin
				pattern_q[g] <= cfg_wdata[LANE +: CHAR_W];
			end
		end
	end

	assign rd_char      = pattern_q[rd_pos[PIDX_W-1:0]];
	assign view.enable  = enable_q;
	assign view.eff_len = (len_q > MAX_LEN) ? MAX_LEN : len_q;

endmodule

// ===== design/wildcard_name_matcher.sv =====
// Wildcard name matcher: streams file-name characters against a glob-like
// pattern, one pattern step per cycle unless a held result stalls the end
// step. Depends on wnm_pkg, wnm_cfg_regs.
// Usage:
//   Input channel (in_valid/in_ready) carries one request per name character:
//   name_char, char_present and name_end. A request with name_end closes the
//   name and produces one is_match result on out_valid/out_ready; other
//   requests produce none. Requests with neither flag are absorbed at once.
//   A request is accepted in IDLE; a character then steps past each '*' at
//   the current pattern position before its compare step, and an end marker
//   steps past each trailing '*' before its final step. in_ready stays low
//   while the single compare/advance step works through the pattern, so a
//   new request is taken only once the last one is done.
//   The result sits in an output register; the next name can start while it
//   waits. If the receiver stalls with a result still held, the following
//   end marker waits in its final step until the register frees up.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written by the user
//   while idle; the block does not enforce this. Writes to indexes past the
//   last register are ignored. Reset clears the pattern, length, enable and
//   all matching state; the block is ready as soon as reset is released.
module wildcard_name_matcher import wnm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     name_char,
	input  logic                  char_present,
	input  logic                  name_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_match
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHAR,
		S_END
	} state_t;

	state_t            state_q;
	logic [CHAR_W-1:0] char_q;
	logic              end_q;
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  resume_q;
	logic              resume_valid_q;
	logic              failed_q;
	logic              out_valid_q;
	logic              is_match_q;

	cfg_view_t         cfg;
	logic [CHAR_W-1:0] pat_char;
	logic              in_range;
	logic              is_star;
	logic              char_hit;
	logic              out_free;
	logic              out_load;
	logic              ok;

	wnm_cfg_regs #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rd_pos    (pos_q),
		.rd_char   (pat_char),
		.view      (cfg)
	);

	assign in_range = pos_q < cfg.eff_len;
	assign is_star  = in_range && (pat_char == CH_STAR);
	assign char_hit = (pat_char == CH_ANY) || (fold_case(pat_char) == fold_case(char_q));
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_END) && !(!failed_q && is_star) && out_free;
	assign ok       = (!failed_q && !in_range) || !cfg.enable;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign is_match  = is_match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			char_q         <= '0;
			end_q          <= 1'b0;
			pos_q          <= '0;
			resume_q       <= '0;
			resume_valid_q <= 1'b0;
			failed_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			is_match_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						char_q <= name_char;
						end_q  <= name_end;
						if (char_present) begin
							state_q <= S_CHAR;
						end else if (name_end) begin
							state_q <= S_END;
						end
					end
				end
				S_CHAR: begin
					if (!failed_q && is_star) begin
						pos_q          <= pos_q + 1'b1;
						resume_q       <= pos_q + 1'b1;
						resume_valid_q <= 1'b1;
					end else begin
						if (!failed_q) begin
							if (in_range && char_hit) begin
								pos_q <= pos_q + 1'b1;
							end else if (resume_valid_q) begin
								pos_q <= resume_q;
							end else begin
								failed_q <= 1'b1;
							end
						end
						state_q <= end_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					if (!failed_q && is_star) begin
						pos_q          <= pos_q + 1'b1;
						resume_q       <= pos_q + 1'b1;
						resume_valid_q <= 1'b1;
					end else if (out_free) begin
						is_match_q     <= ok;
						pos_q          <= '0;
						resume_q       <= '0;
						resume_valid_q <= 1'b0;
						failed_q       <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/wnm_checker.sv =====
// Port-level checks for the wildcard name matcher, bound to the top level.
// Depends on wildcard_name_matcher's port list only.
module wnm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic char_present,
	input logic name_end,
	input logic out_valid,
	input logic out_ready,
	input logic is_match
);

	logic accept;
	assign accept = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_match))
		else $error("result changed or dropped while stalled");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (char_present || name_end) |=> !in_ready)
		else $error("ready high right after a working request");

	a_no_result_for_char: assert property (@(posedge clk) disable iff (!arst_n)
		accept && char_present && !name_end && !out_valid |=> !out_valid)
		else $error("result produced for a character without end");

	a_end_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		accept && name_end && !char_present && !out_valid |=> !out_valid)
		else $error("end marker answered without its final step");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for wildcard_name_matcher: streams file names through a
// local glob predictor and compares every is_match result. Needs wnm_pkg.
module tb_top;
	import wnm_pkg::*;

	localparam int MAX_PAT         = MAX_PATTERN_DEF;
	localparam int SETTLE_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_REQUESTS = 850;
	localparam int REPORT_MAX      = 10;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [CHAR_W-1:0]     name_char    = '0;
	logic                  char_present = 1'b0;
	logic                  name_end     = 1'b0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic                  is_match;

	wildcard_name_matcher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.name_char    (name_char),
		.char_present (char_present),
		.name_end     (name_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_match     (is_match)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// glob predictor state and register copy
	bit          cfg_enable    = 1'b0;
	logic [5:0]  cfg_len       = '0;
	logic [63:0] cfg_words [4] = '{default: '0};
	int          pat_pos       = 0;
	int          resume_at     = 0;
	bit          resume_set    = 1'b0;
	bit          name_failed   = 1'b0;

	bit          pending_match_q [$];
	logic [7:0]  pbuf [32];
	int          mismatches    = 0;
	int          requests_sent = 0;
	int          quiet_cycles  = 0;
	int          stall_left    = 0;
	bit          tx_steady     = 1'b0;
	bit          rx_steady     = 1'b0;

	function automatic int active_len();
		return (cfg_len > MAX_PAT) ? MAX_PAT : int'(cfg_len);
	endfunction

	function automatic logic [7:0] pattern_byte(int i);
		return cfg_words[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic logic [7:0] lower_ascii(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic void skip_wildcards(int len);
		while (pat_pos < len && pattern_byte(pat_pos) == CH_STAR) begin
			pat_pos++;
			resume_at  = pat_pos;
			resume_set = 1'b1;
		end
	endfunction

	function automatic void take_name_char(logic [7:0] c);
		int         len;
		logic [7:0] p;
		len = active_len();
		if (name_failed) begin
			return;
		end
		skip_wildcards(len);
		if (pat_pos >= len) begin
			if (resume_set) begin
				pat_pos = resume_at;
			end else begin
				name_failed = 1'b1;
			end
			return;
		end
		p = pattern_byte(pat_pos);
		if (p == CH_ANY || lower_ascii(p) == lower_ascii(c)) begin
			pat_pos++;
		end else if (resume_set) begin
			pat_pos = resume_at;
		end else begin
			name_failed = 1'b1;
		end
	endfunction

	function automatic void predict_match(logic [7:0] c, bit present, bit fin);
		int len;
		bit m;
		if (present) begin
			take_name_char(c);
		end
		if (fin) begin
			len = active_len();
			if (!name_failed) begin
				skip_wildcards(len);
			end
			m = (!name_failed && pat_pos >= len) || !cfg_enable;
			pending_match_q.push_back(m);
			pat_pos     = 0;
			resume_at   = 0;
			resume_set  = 1'b0;
			name_failed = 1'b0;
		end
	endfunction

	function automatic void flag_mismatch(string what, logic want, logic got);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t mismatch %s: expected %b, got %b", $time, what, want, got);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] common_char(int n);
		case (n)
			0:       return "a";
			1:       return "A";
			2:       return "b";
			3:       return "B";
			4:       return ".";
			5:       return "x";
			6:       return CH_ANY;
			default: return CH_STAR;
		endcase
	endfunction

	function automatic logic [7:0] rand_name_char();
		if ($urandom_range(0, 99) < 75) begin
			return common_char($urandom_range(0, 7));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_pattern_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return CH_STAR;
		end
		if (r < 30) begin
			return CH_ANY;
		end
		if (r < 90) begin
			return common_char($urandom_range(0, 5));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] c);
		if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
				$urandom_range(0, 1)) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	function automatic logic [63:0] pack_word(int w);
		logic [63:0] v;
		int          b;
		for (b = 0; b < 8; b++) begin
			v[b * 8 +: 8] = pbuf[w * 8 + b];
		end
		return v;
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		bit want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_match_q.size() == 0) begin
					flag_mismatch("result with no pending request", 1'bx, is_match);
				end else begin
					want = pending_match_q.pop_front();
					if (is_match !== want) begin
						flag_mismatch("is_match", want, is_match);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!rx_steady && $urandom_range(0, 99) < 20) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	task automatic send_request(logic [7:0] c, bit present, bit fin);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		name_char    <= c;
		char_present <= present;
		name_end     <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_match(c, present, fin);
		if (present || fin) begin
			requests_sent++;
		end
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_match_q.size() != 0);
	endtask

	task automatic settle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_put(cfg_reg_t idx, logic [63:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_MATCH_ENABLE: cfg_enable   = v[0];
			REG_PATTERN_LEN:  cfg_len      = v[5:0];
			REG_CHARS_0_7:    cfg_words[0] = v;
			REG_CHARS_8_15:   cfg_words[1] = v;
			REG_CHARS_16_23:  cfg_words[2] = v;
			REG_CHARS_24_31:  cfg_words[3] = v;
			default: ;
		endcase
	endtask

	// upper bits of the narrow registers carry junk when asked
	task automatic write_config(bit en, logic [5:0] len, bit junk_upper);
		logic [63:0] hi;
		settle();
		hi = junk_upper ? {$urandom, $urandom} : 64'd0;
		cfg_put(REG_MATCH_ENABLE, {hi[63:1], en});
		cfg_put(REG_PATTERN_LEN, {hi[63:6], len});
		cfg_put(REG_CHARS_0_7, pack_word(0));
		cfg_put(REG_CHARS_8_15, pack_word(1));
		cfg_put(REG_CHARS_16_23, pack_word(2));
		cfg_put(REG_CHARS_24_31, pack_word(3));
		cfg_we <= 1'b0;
	endtask

	task automatic fill_pattern(string s);
		int i;
		for (i = 0; i < 32; i++) begin
			if (i < s.len()) begin
				pbuf[i] = s[i];
			end else begin
				pbuf[i] = 8'($urandom_range(0, 255));
			end
		end
	endtask

	task automatic send_name(string s, bit bare_end);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_request(s[i], 1'b1, !bare_end && i == s.len() - 1);
		end
		if (bare_end || s.len() == 0) begin
			send_request(8'h00, 1'b0, 1'b1);
		end
	endtask

	task automatic test_reset_state();
		send_request("a", 1'b1, 1'b1);
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h55, 1'b0, 1'b0);
	endtask

	task automatic test_disabled_pattern();
		fill_pattern("xyz");
		write_config(1'b0, 6'd3, 1'b0);
		send_name("q", 1'b0);
	endtask

	task automatic test_literals_and_any();
		fill_pattern("Ab?");
		write_config(1'b1, 6'd3, 1'b0);
		send_name("aB9", 1'b0);
		send_name("xb", 1'b1);
	endtask

	task automatic test_star_resume();
		fill_pattern("*ab");
		write_config(1'b1, 6'd3, 1'b0);
		send_name("aab", 1'b0);
		fill_pattern("a**");
		write_config(1'b1, 6'd3, 1'b0);
		send_name("a", 1'b1);
		fill_pattern("a*");
		write_config(1'b1, 6'd2, 1'b0);
		send_name("abc", 1'b0);
	endtask

	task automatic test_zero_and_long_length();
		int i;
		fill_pattern("x");
		pbuf[0] = 8'h00;
		write_config(1'b1, 6'd1, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
		for (i = 0; i < 32; i++) begin
			pbuf[i] = CH_STAR;
		end
		write_config(1'b1, 6'd40, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
		write_config(1'b1, 6'd0, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		send_request("a", 1'b1, 1'b1);
	endtask

	task automatic test_mid_name_config();
		fill_pattern("abc");
		write_config(1'b1, 6'd3, 1'b0);
		send_request("a", 1'b1, 1'b0);
		send_request("b", 1'b1, 1'b0);
		write_config(1'b1, 6'd2, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
	endtask

	task automatic random_config(int phase);
		bit         en;
		logic [5:0] len;
		int         i;
		int         r;
		en = 1'b1;
		case (phase)
			0: len = 6'(MAX_PAT);
			1: len = 6'd63;
			2: begin
				en  = 1'b0;
				len = 6'($urandom_range(0, 63));
			end
			3: len = 6'd0;
			default: begin
				r   = $urandom_range(0, 99);
				len = 6'((r < 70) ? $urandom_range(1, 8) :
					(r < 90) ? $urandom_range(9, 32) : $urandom_range(33, 63));
				en  = ($urandom_range(0, 9) != 0);
			end
		endcase
		for (i = 0; i < 32; i++) begin
			if (phase == 2 || $urandom_range(0, 9) == 0) begin
				pbuf[i] = 8'($urandom_range(0, 255));
			end else begin
				pbuf[i] = rand_pattern_char();
			end
		end
		write_config(en, len, phase >= 4 && $urandom_range(0, 1));
	endtask

	// mostly names built to fit the pattern, some mutated, some pure noise
	task automatic send_random_name();
		logic [7:0] nm [$];
		int         len;
		int         i;
		int         k;
		int         n;
		bit         end_on_char;
		len = active_len();
		if ($urandom_range(0, 99) < 80) begin
			for (i = 0; i < len; i++) begin
				if (pattern_byte(i) == CH_STAR) begin
					n = $urandom_range(0, 3);
					repeat (n) nm.push_back(rand_name_char());
				end else if (pattern_byte(i) == CH_ANY) begin
					nm.push_back(rand_name_char());
				end else begin
					nm.push_back(flip_case(pattern_byte(i)));
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, nm.size());
				case ($urandom_range(0, 2))
					0: nm.insert(k, rand_name_char());
					1: if (k < nm.size()) nm.delete(k);
					default: if (k < nm.size()) nm[k] = rand_name_char();
				endcase
			end
		end else begin
			n = $urandom_range(0, 10);
			repeat (n) nm.push_back(rand_name_char());
		end
		end_on_char = 1'($urandom_range(0, 1));
		for (i = 0; i < nm.size(); i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_request(nm[i], 1'b1, end_on_char && i == nm.size() - 1);
		end
		if (!end_on_char || nm.size() == 0) begin
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	task automatic test_random_names();
		int phase;
		int start;
		int quota;
		phase = 0;
		start = requests_sent;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			random_config(phase);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			quota     = requests_sent + $urandom_range(40, 110);
			while (requests_sent < quota) begin
				send_random_name();
				if (phase == 0 || $urandom_range(0, 9) == 0) begin
					wait_results_done();
				end
			end
			phase++;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_disabled_pattern();
		test_literals_and_any();
		test_star_resume();
		test_zero_and_long_length();
		test_mid_name_config();
		test_random_names();
		settle();
		if (mismatches == 0 && pending_match_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
